[rtl/sba_pkg.sv]
// ----------------------------------------------------------------------------
// sba_pkg
// Shared constants, opcodes and the controller command bundle for the
// slot bitmap allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int NUM_SLOTS = 1024;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SLOT_W    = 10;
    localparam int EXT_W     = ((SLOT_W > WORD_AW + BIT_W) ? SLOT_W : WORD_AW + BIT_W) + 1;
    localparam int LAST_BITS = NUM_SLOTS - (NUM_WORDS - 1) * WORD_W;

    localparam logic [WORD_W-1:0]  ONES_WORD = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0]  PAD_MASK  = ~(ONES_WORD >> (WORD_W - LAST_BITS));
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;
    localparam logic [1:0] OP_FILL  = 2'd3;

    typedef struct packed {
        logic latch;
        logic rd_slot;
        logic scan;
        logic rd_find;
        logic write;
        logic fill;
        logic emit_query;
        logic emit_find;
        logic emit_zero;
    } cmd_t;

endpackage

[rtl/sba_ram.sv]
// ----------------------------------------------------------------------------
// sba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/sba_ctrl.sv]
// ----------------------------------------------------------------------------
// sba_ctrl
// Operation sequencer: steps query, mark and find transfers through read,
// scan and result phases (fill-all has none) and issues datapath commands.
// ----------------------------------------------------------------------------
module sba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    opcode,
    output logic          busy,
    output sba_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SCAN,
        S_FREAD,
        S_PICK
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic       take;

    assign busy = (state_reg != S_IDLE);
    assign take = start && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.latch = 1'b1;
                    op_next   = opcode;
                    case (opcode)
                        sba_pkg::OP_QUERY: state_next = S_READ;
                        sba_pkg::OP_MARK:  state_next = S_READ;
                        sba_pkg::OP_FIND:  state_next = S_SCAN;
                        default:
                        begin
                            cmd.fill      = 1'b1;
                            cmd.emit_zero = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = S_EVAL;
            end
            S_EVAL:
            begin
                if (op_reg == sba_pkg::OP_MARK)
                begin
                    cmd.write     = 1'b1;
                    cmd.emit_zero = 1'b1;
                end
                else
                begin
                    cmd.emit_query = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_FREAD;
            end
            S_FREAD:
            begin
                cmd.rd_find = 1'b1;
                state_next  = S_PICK;
            end
            S_PICK:
            begin
                cmd.emit_find = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= sba_pkg::OP_QUERY;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

[rtl/sba_datapath.sv]
// ----------------------------------------------------------------------------
// sba_datapath
// Bitmap word store with per-word valid, default and full summary bits,
// first-free search and result registers.
// ----------------------------------------------------------------------------
module sba_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sba_pkg::cmd_t              cmd,
    input  logic [sba_pkg::SLOT_W-1:0] slot_index,
    input  logic                       mark_value,
    output logic                       done,
    output logic                       slot_used,
    output logic                       found,
    output logic [sba_pkg::SLOT_W-1:0] free_slot
);

    logic [sba_pkg::SLOT_W-1:0]    idx_reg;
    logic                          val_reg;
    logic [sba_pkg::EXT_W-1:0]     idx_ext;
    logic                          in_range;
    logic [sba_pkg::WORD_AW-1:0]   slot_word;
    logic [sba_pkg::BIT_W-1:0]     slot_bit;

    logic [sba_pkg::NUM_WORDS-1:0] valid_reg;
    logic [sba_pkg::NUM_WORDS-1:0] def_reg;
    logic [sba_pkg::NUM_WORDS-1:0] full_reg;

    logic [sba_pkg::WORD_AW-1:0]   rd_word_reg;
    logic [sba_pkg::WORD_AW-1:0]   raddr;
    logic                          re;
    logic [sba_pkg::WORD_W-1:0]    rdata;
    logic [sba_pkg::WORD_W-1:0]    eff_word;
    logic [sba_pkg::WORD_W-1:0]    new_word;
    logic [sba_pkg::WORD_W-1:0]    pad_word;
    logic                          we;

    logic [sba_pkg::WORD_AW-1:0]   scan_word;
    logic                          scan_any;
    logic [sba_pkg::WORD_AW-1:0]   find_word_reg;
    logic                          find_any_reg;
    logic [sba_pkg::BIT_W-1:0]     zero_bit;

    logic                          done_reg;
    logic                          used_reg;
    logic                          found_reg;
    logic [sba_pkg::SLOT_W-1:0]    free_reg;

    assign idx_ext   = sba_pkg::EXT_W'(idx_reg);
    assign in_range  = idx_ext < sba_pkg::EXT_W'(sba_pkg::NUM_SLOTS);
    assign slot_word = idx_ext[sba_pkg::WORD_AW+sba_pkg::BIT_W-1:sba_pkg::BIT_W];
    assign slot_bit  = idx_ext[sba_pkg::BIT_W-1:0];

    assign re    = cmd.rd_slot || cmd.rd_find;
    assign raddr = cmd.rd_find ? find_word_reg : slot_word;

    sba_ram #(
        .WIDTH (sba_pkg::WORD_W),
        .DEPTH (sba_pkg::NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (rd_word_reg),
        .wdata (new_word),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign eff_word = valid_reg[rd_word_reg] ? rdata
                                             : {sba_pkg::WORD_W{def_reg[rd_word_reg]}};
    assign pad_word = eff_word | ((rd_word_reg == sba_pkg::LAST_WORD) ? sba_pkg::PAD_MASK : '0);
    assign we       = cmd.write && in_range;

    always_comb
    begin
        new_word           = eff_word;
        new_word[slot_bit] = val_reg;
    end

    always_comb
    begin
        scan_word = '0;
        scan_any  = 1'b0;
        for (int w = sba_pkg::NUM_WORDS - 1; w >= 0; w--)
        begin
            if (!full_reg[w])
            begin
                scan_word = sba_pkg::WORD_AW'(w);
                scan_any  = 1'b1;
            end
        end
    end

    always_comb
    begin
        zero_bit = '0;
        for (int b = sba_pkg::WORD_W - 1; b >= 0; b--)
        begin
            if (!pad_word[b])
            begin
                zero_bit = sba_pkg::BIT_W'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            def_reg   <= '0;
            full_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_query || cmd.emit_find || cmd.emit_zero;
            if (cmd.fill)
            begin
                valid_reg <= '0;
                def_reg   <= '1;
                full_reg  <= '1;
            end
            else if (we)
            begin
                valid_reg[rd_word_reg] <= 1'b1;
                full_reg[rd_word_reg]  <= &(new_word | ((rd_word_reg == sba_pkg::LAST_WORD)
                                                        ? sba_pkg::PAD_MASK : '0));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            idx_reg <= slot_index;
            val_reg <= mark_value;
        end
        if (re)
        begin
            rd_word_reg <= raddr;
        end
        if (cmd.scan)
        begin
            find_word_reg <= scan_word;
            find_any_reg  <= scan_any;
        end
        if (cmd.emit_zero)
        begin
            used_reg  <= 1'b0;
            found_reg <= 1'b0;
            free_reg  <= '0;
        end
        else if (cmd.emit_query)
        begin
            used_reg  <= in_range && eff_word[slot_bit];
            found_reg <= 1'b0;
            free_reg  <= '0;
        end
        else if (cmd.emit_find)
        begin
            used_reg  <= 1'b0;
            found_reg <= find_any_reg;
            free_reg  <= find_any_reg ? sba_pkg::SLOT_W'({find_word_reg, zero_bit}) : '0;
        end
    end

    assign done      = done_reg;
    assign slot_used = used_reg;
    assign found     = found_reg;
    assign free_slot = free_reg;

endmodule

[rtl/slot_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// slot_bitmap_allocator
// Bitmap of used slots with query, mark, find-first-free and fill-all.
//
//   Channel  | Handshake        | Signals
//   ---------+------------------+------------------------------------------
//   command  | start / busy     | opcode, slot_index, mark_value
//   result   | done (1 cycle)   | slot_used, found, free_slot
//
// Fill-all: result in the cycle after the transfer, next command the cycle
// after the transfer. Query and mark pass S_READ (registered word-memory
// read) and S_EVAL; find: S_SCAN (full-word summary scan), S_FREAD, S_PICK.
// Reset clears the valid and full summary bits at once: no clearing pass.
// The receiver cannot stall; done marks each result for one cycle.
// ----------------------------------------------------------------------------
module slot_bitmap_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 opcode,
    input  logic [sba_pkg::SLOT_W-1:0] slot_index,
    input  logic                       mark_value,
    output logic                       done,
    output logic                       slot_used,
    output logic                       found,
    output logic [sba_pkg::SLOT_W-1:0] free_slot
);

    sba_pkg::cmd_t cmd;

    sba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .busy   (busy),
        .cmd    (cmd)
    );

    sba_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .slot_index (slot_index),
        .mark_value (mark_value),
        .done       (done),
        .slot_used  (slot_used),
        .found      (found),
        .free_slot  (free_slot)
    );

endmodule

[verif/tb_slot_bitmap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_bitmap_allocator
// Self-checking bench for the slot bitmap allocator. A queue-fed driver sends
// query, mark, find-first-free and fill-all commands with random gaps. A
// monitor keeps a mirror of the used-slot bitmap and predicts every result.
// Each result strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_slot_bitmap_allocator;

    localparam int N_ITEMS    = 1900;
    localparam int IDLE_PCT   = 9;
    localparam int LIMIT      = 200000;
    localparam int TAIL_CYCLES = 12;

    typedef struct {
        logic [1:0]                 op;
        logic [sba_pkg::SLOT_W-1:0] idx;
        logic                       val;
        bit                         drain_first;
        bit                         steady;
    } alloc_cmd_t;

    typedef struct {
        logic                       used;
        logic                       found;
        logic [sba_pkg::SLOT_W-1:0] slot;
    } alloc_res_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    opcode = sba_pkg::OP_QUERY;
    logic [sba_pkg::SLOT_W-1:0]    slot_index = '0;
    logic                          mark_value = 1'b0;
    logic                          done;
    logic                          slot_used;
    logic                          found;
    logic [sba_pkg::SLOT_W-1:0]    free_slot;

    alloc_cmd_t                    pending_cmds[$];
    alloc_res_t                    expected_results[$];
    logic [sba_pkg::NUM_SLOTS-1:0] slot_map;
    int                            n_items = 0;
    int                            n_errors = 0;
    int                            cycle_count = 0;

    slot_bitmap_allocator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .slot_index (slot_index),
        .mark_value (mark_value),
        .done       (done),
        .slot_used  (slot_used),
        .found      (found),
        .free_slot  (free_slot)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic alloc_res_t predict_result(alloc_cmd_t c);
        alloc_res_t r;
        bit         hit;
        int         pos;
        r   = '{used: 1'b0, found: 1'b0, slot: '0};
        hit = 1'b0;
        pos = 0;
        case (c.op)
            sba_pkg::OP_QUERY:
            begin
                if (int'(c.idx) < sba_pkg::NUM_SLOTS)
                    r.used = slot_map[c.idx];
            end
            sba_pkg::OP_MARK:
            begin
                if (int'(c.idx) < sba_pkg::NUM_SLOTS)
                    slot_map[c.idx] = c.val;
            end
            sba_pkg::OP_FIND:
            begin
                for (int s = sba_pkg::NUM_SLOTS - 1; s >= 0; s--)
                begin
                    if (!slot_map[s])
                    begin
                        hit = 1'b1;
                        pos = s;
                    end
                end
                if (hit)
                begin
                    r.found = 1'b1;
                    r.slot  = sba_pkg::SLOT_W'(pos);
                end
            end
            default:
            begin
                slot_map = '1;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic add_cmd(logic [1:0] op, int idx, logic val);
        alloc_cmd_t c;
        c.op          = op;
        c.idx         = sba_pkg::SLOT_W'(idx);
        c.val         = val;
        c.drain_first = (n_items == 900);
        c.steady      = (n_items >= 1200 && n_items < 1500);
        pending_cmds.push_back(c);
        n_items++;
    endtask

    // driver: present the oldest pending command, with random gaps
    always @(negedge clk)
    begin
        if (!rst_n || pending_cmds.size() == 0 ||
            (pending_cmds[0].drain_first && expected_results.size() != 0) ||
            (!pending_cmds[0].steady && $urandom_range(0, 99) < IDLE_PCT))
        begin
            start      <= 1'b0;
            opcode     <= 2'($urandom_range(0, 3));
            slot_index <= sba_pkg::SLOT_W'($urandom);
            mark_value <= 1'($urandom);
        end
        else
        begin
            start      <= 1'b1;
            opcode     <= pending_cmds[0].op;
            slot_index <= pending_cmds[0].idx;
            mark_value <= pending_cmds[0].val;
        end
    end

    // monitor: check results first, then predict the new transfer
    always @(posedge clk)
    begin
        alloc_res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result, slot", free_slot, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (slot_used !== want.used)
                        report_mismatch("slot_used", slot_used, want.used);
                    if (found !== want.found)
                        report_mismatch("found", found, want.found);
                    if (free_slot !== want.slot)
                        report_mismatch("free_slot", free_slot, want.slot);
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(predict_result(pending_cmds.pop_front()));
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int recent[$];
        int s;
        slot_map = '0;

        add_cmd(sba_pkg::OP_QUERY, 0, 1'b0);
        add_cmd(sba_pkg::OP_QUERY, sba_pkg::NUM_SLOTS - 1, 1'b1);
        add_cmd(sba_pkg::OP_FIND, 0, 1'b0);
        add_cmd(sba_pkg::OP_MARK, 0, 1'b1);
        add_cmd(sba_pkg::OP_MARK, sba_pkg::NUM_SLOTS - 1, 1'b1);
        add_cmd(sba_pkg::OP_QUERY, 0, 1'b0);
        add_cmd(sba_pkg::OP_QUERY, sba_pkg::NUM_SLOTS - 1, 1'b0);
        add_cmd(sba_pkg::OP_FIND, sba_pkg::NUM_SLOTS - 1, 1'b1);
        add_cmd(sba_pkg::OP_MARK, 0, 1'b0);
        add_cmd(sba_pkg::OP_FIND, 0, 1'b0);
        add_cmd(sba_pkg::OP_FILL, 'h2AA, 1'b1);
        add_cmd(sba_pkg::OP_FIND, 0, 1'b0);
        add_cmd(sba_pkg::OP_QUERY, 0, 1'b0);
        add_cmd(sba_pkg::OP_QUERY, 'h155, 1'b0);
        add_cmd(sba_pkg::OP_QUERY, sba_pkg::NUM_SLOTS - 1, 1'b0);
        add_cmd(sba_pkg::OP_MARK, sba_pkg::NUM_SLOTS - 1, 1'b0);
        add_cmd(sba_pkg::OP_FIND, 0, 1'b0);
        add_cmd(sba_pkg::OP_MARK, sba_pkg::NUM_SLOTS - 1, 1'b1);
        add_cmd(sba_pkg::OP_FIND, 0, 1'b0);
        add_cmd(sba_pkg::OP_MARK, 5, 1'b0);
        add_cmd(sba_pkg::OP_MARK, 'h2AA, 1'b0);
        add_cmd(sba_pkg::OP_FIND, 0, 1'b0);
        add_cmd(sba_pkg::OP_MARK, 5, 1'b1);
        add_cmd(sba_pkg::OP_FIND, 0, 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_items < N_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(6, 16))
                    add_cmd(2'($urandom_range(0, 3)),
                            $urandom_range(0, (1 << sba_pkg::SLOT_W) - 1), 1'($urandom));
            end
            else
            begin
                // allocate session: fill, free a few slots, then use them up
                recent.delete();
                add_cmd(sba_pkg::OP_FILL, $urandom_range(0, (1 << sba_pkg::SLOT_W) - 1),
                        1'($urandom));
                repeat ($urandom_range(1, 6))
                begin
                    s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, sba_pkg::NUM_SLOTS - 1);
                    recent.push_back(s);
                    add_cmd(sba_pkg::OP_MARK, s, 1'b0);
                end
                add_cmd(sba_pkg::OP_FIND, $urandom_range(0, (1 << sba_pkg::SLOT_W) - 1),
                        1'($urandom));
                repeat ($urandom_range(8, 30))
                begin
                    s = ($urandom_range(0, 2) != 0) ? recent[$urandom_range(0, recent.size() - 1)]
                                                    : $urandom_range(0, sba_pkg::NUM_SLOTS - 1);
                    case ($urandom_range(0, 9)) inside
                        [0:2]:   add_cmd(sba_pkg::OP_QUERY, s, 1'($urandom));
                        [3:5]:   add_cmd(sba_pkg::OP_MARK, s, ($urandom_range(0, 9) < 7));
                        default: add_cmd(sba_pkg::OP_FIND, s, 1'($urandom));
                    endcase
                end
            end
        end

        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
